### design/tmcd_pkg.sv
// Package with the types, constants and keyword tables of the text motor command decoder.
package tmcd_pkg;

   localparam int VALUE_W = 10;
   localparam int BYTE_W = 8;
   localparam int NUM_KW = 5;
   localparam int KW_MAX = 8;
   localparam int PROG_W = 3;
   localparam int CSR_INDEX_W = 2;

   localparam int FRAME_CHARS_DEF = 63;

   localparam logic [VALUE_W-1:0] SPEED_START_RST = 10'd200;
   localparam logic [VALUE_W-1:0] SPEED_STEP_RST = 10'd100;
   localparam logic [VALUE_W-1:0] SPEED_LIMIT_RST = 10'd900;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_START = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_STEP = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPEED_LIMIT = 2'd2;

   localparam logic [BYTE_W-1:0] NUL_CHAR = 8'h00;

   // Keyword slots, in order of priority at the end of a frame.
   localparam int KW_AVANCE = 0;
   localparam int KW_ARRIERE = 1;
   localparam int KW_GAUCHE = 2;
   localparam int KW_DROITE = 3;
   localparam int KW_STOP = 4;

   localparam logic [BYTE_W-1:0] KW_TEXT [NUM_KW][KW_MAX] = '{
      '{8'h41, 8'h56, 8'h41, 8'h4E, 8'h43, 8'h45, 8'h00, 8'h00},
      '{8'h41, 8'h52, 8'h52, 8'h49, 8'h45, 8'h52, 8'h45, 8'h00},
      '{8'h47, 8'h41, 8'h55, 8'h43, 8'h48, 8'h45, 8'h00, 8'h00},
      '{8'h44, 8'h52, 8'h4F, 8'h49, 8'h54, 8'h45, 8'h00, 8'h00},
      '{8'h53, 8'h54, 8'h4F, 8'h50, 8'h00, 8'h00, 8'h00, 8'h00}
   };

   localparam logic [PROG_W-1:0] KW_LEN [NUM_KW] = '{3'd6, 3'd7, 3'd6, 3'd6, 3'd4};

   typedef struct packed {
      logic [VALUE_W-1:0] speed_start;
      logic [VALUE_W-1:0] speed_step;
      logic [VALUE_W-1:0] speed_limit;
   } csr_regs_type;

   typedef struct packed {
      logic clear;
      logic step;
   } match_ctl_type;

   // Longest keyword prefix that ends the text matched so far plus the new character.
   function automatic logic [PROG_W-1:0] kw_next(input int kw, input logic [PROG_W-1:0] p,
                                                 input logic [BYTE_W-1:0] c);
      int pb;
      int idx;
      logic ok;
      logic found;
      logic [PROG_W-1:0] res;
      pb = (p >= KW_LEN[kw]) ? 0 : int'(p);
      res = '0;
      found = 1'b0;
      for (int k = KW_MAX - 1; k >= 1; k--) begin
         ok = (k <= pb + 1) && (k <= int'(KW_LEN[kw])) && (KW_TEXT[kw][k-1] == c);
         for (int j = 0; j < KW_MAX - 1; j++) begin
            idx = pb + 1 - k + j;
            if (j < k - 1 && idx >= 0 && idx < KW_MAX) begin
               ok = ok && (KW_TEXT[kw][j] == KW_TEXT[kw][idx]);
            end
         end
         if (ok && !found) begin
            res = PROG_W'(k);
            found = 1'b1;
         end
      end
      return res;
   endfunction

endpackage

### design/tmcd_kw_match.sv
// One keyword matcher: match progress and a found flag for a single keyword.
module tmcd_kw_match
   import tmcd_pkg::*;
#(
   parameter int KW_IDX = 0
) (
   input  logic                clock,
   input  logic                reset,
   input  match_ctl_type       ctl,
   input  logic [BYTE_W-1:0]   rx_byte,
   output logic                seen
);

   logic [PROG_W-1:0] prog_ff, prog_in;
   logic              seen_ff, seen_in;
   logic [PROG_W-1:0] prog_base, prog_step;
   logic              seen_base;

   always_comb begin
      prog_base = ctl.clear ? '0 : prog_ff;
      seen_base = ctl.clear ? 1'b0 : seen_ff;
      prog_step = kw_next(KW_IDX, prog_base, rx_byte);
      prog_in = prog_base;
      seen_in = seen_base;
      if (ctl.step) begin
         if (prog_step >= KW_LEN[KW_IDX]) begin
            prog_in = '0;
            seen_in = 1'b1;
         end else begin
            prog_in = prog_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prog_ff <= '0;
         seen_ff <= 1'b0;
      end else if (ctl.clear || ctl.step) begin
         prog_ff <= prog_in;
         seen_ff <= seen_in;
      end
   end

   assign seen = seen_ff;

endmodule

### design/tmcd_drive.sv
// Speed and H-bridge duty registers, updated once per end of frame.
module tmcd_drive
   import tmcd_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 frame_end,
   input  logic [NUM_KW-1:0]    kw_seen,
   input  csr_regs_type         regs,
   output logic [VALUE_W-1:0]   right_forward_duty,
   output logic [VALUE_W-1:0]   right_reverse_duty,
   output logic [VALUE_W-1:0]   left_forward_duty,
   output logic [VALUE_W-1:0]   left_reverse_duty,
   output logic [VALUE_W-1:0]   current_speed
);

   logic [VALUE_W-1:0] speed_ff, speed_in;
   logic [VALUE_W-1:0] rf_ff, rf_in, rr_ff, rr_in, lf_ff, lf_in, lr_ff, lr_in;
   logic [VALUE_W:0]   speed_sum;
   logic [VALUE_W-1:0] speed_move;
   logic [VALUE_W-1:0] speed_half;

   always_comb begin
      speed_sum = {1'b0, speed_ff} + {1'b0, regs.speed_step};
      if (speed_ff < regs.speed_limit && speed_sum <= {1'b0, regs.speed_limit}) begin
         speed_move = speed_sum[VALUE_W-1:0];
      end else begin
         speed_move = regs.speed_limit;
      end
      speed_half = speed_move >> 1;

      speed_in = speed_ff;
      rf_in = rf_ff;
      rr_in = rr_ff;
      lf_in = lf_ff;
      lr_in = lr_ff;
      if (|kw_seen[KW_DROITE:KW_AVANCE]) begin
         speed_in = speed_move;
      end
      priority if (kw_seen[KW_AVANCE]) begin
         rf_in = speed_move;
         rr_in = '0;
         lf_in = speed_move;
         lr_in = '0;
      end else if (kw_seen[KW_ARRIERE]) begin
         rf_in = '0;
         rr_in = speed_move;
         lf_in = '0;
         lr_in = speed_move;
      end else if (kw_seen[KW_GAUCHE]) begin
         rf_in = speed_move;
         rr_in = '0;
         lf_in = speed_half;
         lr_in = '0;
      end else if (kw_seen[KW_DROITE]) begin
         rf_in = speed_half;
         rr_in = '0;
         lf_in = speed_move;
         lr_in = '0;
      end else if (kw_seen[KW_STOP]) begin
         speed_in = regs.speed_start;
         rf_in = '0;
         rr_in = '0;
         lf_in = '0;
         lr_in = '0;
      end else begin
         speed_in = speed_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         speed_ff <= SPEED_START_RST;
         rf_ff <= '0;
         rr_ff <= '0;
         lf_ff <= '0;
         lr_ff <= '0;
      end else if (frame_end) begin
         speed_ff <= speed_in;
         rf_ff <= rf_in;
         rr_ff <= rr_in;
         lf_ff <= lf_in;
         lr_ff <= lr_in;
      end
   end

   assign right_forward_duty = rf_ff;
   assign right_reverse_duty = rr_ff;
   assign left_forward_duty = lf_ff;
   assign left_reverse_duty = lr_ff;
   assign current_speed = speed_ff;

endmodule

### design/text_motor_command_decoder.sv
// Text motor command decoder: keyword search over received frames and motor duty control.
// A request is first taken into the input register and is processed when it moves on; the
// result of an end-of-frame request is shown on the rsp_ port from then on.
// Throughput: one request per cycle; the input register and the result register only
// hold the flow while a finished result waits on rsp_stall.
// Reset (synchronous, active high) clears the frame and match state, loads the register
// reset values, sets the speed to 200 and all duties to zero, and drops any pending result.
module text_motor_command_decoder
   import tmcd_pkg::*;
#(
   parameter int FRAME_CHARS = FRAME_CHARS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_command,
   input  logic [BYTE_W-1:0]        req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [VALUE_W-1:0]       rsp_right_forward_duty,
   output logic [VALUE_W-1:0]       rsp_right_reverse_duty,
   output logic [VALUE_W-1:0]       rsp_left_forward_duty,
   output logic [VALUE_W-1:0]       rsp_left_reverse_duty,
   output logic [VALUE_W-1:0]       rsp_current_speed,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [VALUE_W-1:0]       csr_write_data
);

   localparam int CNT_W = $clog2(FRAME_CHARS + 1);
   localparam logic [CNT_W-1:0] FRAME_FULL = CNT_W'(FRAME_CHARS);

   // Configuration registers. Index three is outside the map and is ignored.
   csr_regs_type regs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff.speed_start <= SPEED_START_RST;
         regs_ff.speed_step <= SPEED_STEP_RST;
         regs_ff.speed_limit <= SPEED_LIMIT_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SPEED_START: regs_ff.speed_start <= csr_write_data;
            CSR_SPEED_STEP:  regs_ff.speed_step <= csr_write_data;
            CSR_SPEED_LIMIT: regs_ff.speed_limit <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Input register. A new request is taken whenever the register is empty or its
   // request moves on in this cycle. The only thing that holds a request back is a
   // result that waits on rsp_stall.
   logic              in_valid_ff, in_valid_in;
   logic              in_command_ff;
   logic [BYTE_W-1:0] in_byte_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              advance;
   logic              fire;

   assign advance = !(rsp_valid_ff && rsp_stall);
   assign fire = in_valid_ff && advance;
   assign req_stall = in_valid_ff && !advance;

   always_comb begin
      if (req_valid && !req_stall) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_command_ff <= req_command;
         in_byte_ff <= req_rx_byte;
      end
   end

   // Frame bookkeeping. After an overflow the next character first wipes the frame,
   // so the stored count and the ended flag are read through that pending restart.
   logic [CNT_W-1:0] count_ff, count_in, count_eff;
   logic             ended_ff, ended_in, ended_eff;
   logic             restart_ff, restart_in;
   logic             overflow;
   logic             char_fire;
   logic             frame_end;
   match_ctl_type    match_ctl;

   always_comb begin
      char_fire = fire && !in_command_ff;
      frame_end = fire && in_command_ff;
      count_eff = restart_ff ? '0 : count_ff;
      ended_eff = restart_ff ? 1'b0 : ended_ff;
      overflow = count_eff >= FRAME_FULL;

      count_in = count_ff;
      ended_in = ended_ff;
      restart_in = restart_ff;
      if (frame_end) begin
         count_in = '0;
         ended_in = 1'b0;
         restart_in = 1'b0;
      end else if (char_fire) begin
         if (overflow) begin
            count_in = '0;
            ended_in = ended_eff;
            restart_in = 1'b1;
         end else begin
            count_in = count_eff + 1'b1;
            ended_in = ended_eff || (in_byte_ff == NUL_CHAR);
            restart_in = 1'b0;
         end
      end

      // The matchers are wiped at the end of a frame and on a restart; they step on
      // every stored character before the first NUL byte of the frame.
      match_ctl.clear = frame_end || (char_fire && restart_ff);
      match_ctl.step = char_fire && !overflow && !ended_eff && (in_byte_ff != NUL_CHAR);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ended_ff <= 1'b0;
         restart_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ended_ff <= ended_in;
         restart_ff <= restart_in;
      end
   end

   // Five keyword matchers work side by side on each character.
   logic [NUM_KW-1:0] kw_seen;

   for (genvar g = 0; g < NUM_KW; g++) begin : g_kw
      tmcd_kw_match #(
         .KW_IDX(g)
      ) u_kw_match (
         .clock(clock),
         .reset(reset),
         .ctl(match_ctl),
         .rx_byte(in_byte_ff),
         .seen(kw_seen[g])
      );
   end

   // The speed and duty registers change only at an end of frame, and an end of frame
   // is processed only when the result register is free, so they serve directly as
   // the result payload.
   tmcd_drive u_drive (
      .clock(clock),
      .reset(reset),
      .frame_end(frame_end),
      .kw_seen(kw_seen),
      .regs(regs_ff),
      .right_forward_duty(rsp_right_forward_duty),
      .right_reverse_duty(rsp_right_reverse_duty),
      .left_forward_duty(rsp_left_forward_duty),
      .left_reverse_duty(rsp_left_reverse_duty),
      .current_speed(rsp_current_speed)
   );

   always_comb begin
      if (frame_end) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && rsp_stall) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### design/tmcd_checker.sv
// Port-level checker for the text motor command decoder, bound to the top level.
module tmcd_checker
   import tmcd_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_command,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input logic [VALUE_W-1:0]  rsp_right_forward_duty,
   input logic [VALUE_W-1:0]  rsp_right_reverse_duty,
   input logic [VALUE_W-1:0]  rsp_left_forward_duty,
   input logic [VALUE_W-1:0]  rsp_left_reverse_duty,
   input logic [VALUE_W-1:0]  rsp_current_speed
);

   // No result is left over after a reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A new result must trace back to an end-of-frame request that was taken.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall && req_command, 2))
      else $error("result without a matching end-of-frame request");

   // A result held by rsp_stall stays and keeps its speed.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_current_speed))
      else $error("stalled result changed");

   // Neither motor is ever driven forward and in reverse at once.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_right_forward_duty != '0 && rsp_right_reverse_duty != '0) &&
                    !(rsp_left_forward_duty != '0 && rsp_left_reverse_duty != '0))
      else $error("both half bridges of one motor driven");

endmodule

bind text_motor_command_decoder tmcd_checker u_tmcd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .req_command(req_command),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_right_forward_duty(rsp_right_forward_duty),
   .rsp_right_reverse_duty(rsp_right_reverse_duty),
   .rsp_left_forward_duty(rsp_left_forward_duty),
   .rsp_left_reverse_duty(rsp_left_reverse_duty),
   .rsp_current_speed(rsp_current_speed)
);
